[sv/per_symbol_phase_derotator_macros.svh]
// Assertion macros for the per-symbol phase derotator.
// Depends on nothing; taken in by the modules that assert.
`ifndef PER_SYMBOL_PHASE_DEROTATOR_MACROS_SVH
`define PER_SYMBOL_PHASE_DEROTATOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PSD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define PSD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/psd_pkg.sv]
// Package of the per-symbol phase derotator: frame sizes, Q15 constants,
// register indexes and the complex sample type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

   localparam int SAMPLES_PER_SYMBOL = 12;
   localparam int SYMBOLS_PER_BLOCK  = 7;

   localparam int SC_W  = $clog2(SAMPLES_PER_SYMBOL > 1 ? SAMPLES_PER_SYMBOL : 2);
   localparam int SYM_W = $clog2(SYMBOLS_PER_BLOCK > 1 ? SYMBOLS_PER_BLOCK : 2);

   localparam logic [SC_W-1:0]  SC_LAST  = SC_W'(SAMPLES_PER_SYMBOL - 1);
   localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(SYMBOLS_PER_BLOCK - 1);

   localparam int Q15_W   = 16;
   localparam int Q15_SHIFT = 15;
   localparam logic signed [Q15_W-1:0] Q15_ONE  = 16'sh7FFF;
   localparam logic signed [Q15_W-1:0] Q15_ZERO = 16'sh0000;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_STEP_RE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_STEP_IM = 1'd1;

   typedef struct packed {
      logic signed [Q15_W-1:0] im;
      logic signed [Q15_W-1:0] re;
   } cplx_type;

endpackage

`default_nettype wire

[sv/per_symbol_phase_derotator.sv]
// Per-symbol phase derotator top level: counters, phase state, two-stage pipe.
// Depends on psd_pkg, psd_cmul and per_symbol_phase_derotator_macros.svh.
//
// Usage:
//   req_* carries one complex Q15 sample per request, rsp_* one derotated
//   sample per request, with rsp_tlast high on the final sample of a block.
//   Samples are counted into symbols of 12 and blocks of 7 symbols; each
//   sample is multiplied by the conjugate of the current phase, and after
//   the last sample of a symbol the phase advances by the step phasor in
//   csr registers 0 (real) and 1 (imaginary). A block restarts at 0x7FFF+0j.
//   A request passes the first stage and then the output register to rsp_tvalid.
//   Throughput: 1 request per cycle unless the receiver stalls; the phase
//   update is one complex multiply in the cycle of acceptance, the sample product one stage later.
//   Reset clears the pipe and counters, sets phase to 0x7FFF+0j and the
//   step phasor to 0x7FFF+0j.
//   When the receiver stalls, the result holds and one more request is
//   buffered in the first stage; req_tready then drops until rsp_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "per_symbol_phase_derotator_macros.svh"

module per_symbol_phase_derotator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_re [15:0], sample_im [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // rot_re [15:0], rot_im [31:16]
   output logic        rsp_tlast,   // block_last
   input  logic        csr_we,
   input  logic [psd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   psd_pkg::cplx_type step_ff, step_in;
   psd_pkg::cplx_type phase_ff, phase_in, phase_next;
   logic [psd_pkg::SC_W-1:0]  sc_ff, sc_in;
   logic [psd_pkg::SYM_W-1:0] sym_ff, sym_in;

   logic              s1_valid_ff, s1_valid_in;
   psd_pkg::cplx_type s1_sample_ff;
   psd_pkg::cplx_type s1_conj_ff;
   logic              s1_last_ff;
   psd_pkg::cplx_type rot;

   logic              out_valid_ff, out_valid_in;
   psd_pkg::cplx_type out_rot_ff;
   logic              out_last_ff;

   logic accept, sym_end, blk_end, out_en, s1_en;

   assign out_en     = !out_valid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || out_en;
   assign req_tready = s1_en;
   assign accept     = req_tvalid && req_tready;
   assign sym_end    = (sc_ff == psd_pkg::SC_LAST);
   assign blk_end    = sym_end && (sym_ff == psd_pkg::SYM_LAST);

   psd_cmul u_phase_step (
      .a (phase_ff),
      .b (step_ff),
      .p (phase_next)
   );

   psd_cmul u_derot (
      .a (s1_sample_ff),
      .b (s1_conj_ff),
      .p (rot)
   );

   always_comb begin
      step_in = step_ff;
      if (csr_we) begin
         case (csr_index)
            psd_pkg::CSR_FREQ_STEP_RE: step_in.re = csr_wdata;
            psd_pkg::CSR_FREQ_STEP_IM: step_in.im = csr_wdata;
            default: step_in = step_ff;
         endcase
      end
   end

   always_comb begin
      sc_in    = sc_ff;
      sym_in   = sym_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (!sym_end) begin
            sc_in = psd_pkg::SC_W'(sc_ff + 1'b1);
         end else begin
            sc_in = '0;
            if (blk_end) begin
               sym_in      = '0;
               phase_in.re = psd_pkg::Q15_ONE;
               phase_in.im = psd_pkg::Q15_ZERO;
            end else begin
               sym_in   = psd_pkg::SYM_W'(sym_ff + 1'b1);
               phase_in = phase_next;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_en ? accept : s1_valid_ff;
      out_valid_in = out_en ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.re   <= psd_pkg::Q15_ONE;
         step_ff.im   <= psd_pkg::Q15_ZERO;
         phase_ff.re  <= psd_pkg::Q15_ONE;
         phase_ff.im  <= psd_pkg::Q15_ZERO;
         sc_ff        <= '0;
         sym_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         sc_ff        <= sc_in;
         sym_ff       <= sym_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_tdata;
         s1_conj_ff.re <= phase_ff.re;
         s1_conj_ff.im <= psd_pkg::Q15_W'(psd_pkg::Q15_ZERO - phase_ff.im);
         s1_last_ff   <= blk_end;
      end
      if (out_en && s1_valid_ff) begin
         out_rot_ff  <= rot;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_rot_ff;
   assign rsp_tlast  = out_last_ff;

   `PSD_ASSERT(a_sc_range, clock, reset, sc_ff <= psd_pkg::SC_LAST, "subcarrier count out of range")
   `PSD_ASSERT(a_sym_range, clock, reset, sym_ff <= psd_pkg::SYM_LAST, "symbol count out of range")
   `PSD_ASSERT_NEXT(a_blk_restart, clock, reset, accept && blk_end, (phase_ff.re == psd_pkg::Q15_ONE) && (phase_ff.im == psd_pkg::Q15_ZERO), "phase not restarted at block end")
   `PSD_ASSERT_NEXT(a_phase_hold, clock, reset, !(accept && sym_end), $stable(phase_ff), "phase moved inside a symbol")
   `PSD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !out_en, s1_valid_ff && $stable(s1_sample_ff), "first stage lost a request while stalled")

endmodule

`default_nettype wire

[sv/psd_cmul.sv]
// Q15 complex multiplier: product bits 15..30 of each part, wrapping.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_cmul (
   input  psd_pkg::cplx_type a,
   input  psd_pkg::cplx_type b,
   output psd_pkg::cplx_type p
);

   logic signed [2*psd_pkg::Q15_W-1:0] rr, ii, ri, ir;
   logic signed [2*psd_pkg::Q15_W:0]   sum_re, sum_im;

   always_comb begin
      rr = a.re * b.re;
      ii = a.im * b.im;
      ri = a.re * b.im;
      ir = a.im * b.re;
      sum_re = (2*psd_pkg::Q15_W+1)'(rr) - (2*psd_pkg::Q15_W+1)'(ii);
      sum_im = (2*psd_pkg::Q15_W+1)'(ri) + (2*psd_pkg::Q15_W+1)'(ir);
      p.re = sum_re[psd_pkg::Q15_SHIFT +: psd_pkg::Q15_W];
      p.im = sum_im[psd_pkg::Q15_SHIFT +: psd_pkg::Q15_W];
   end

endmodule

`default_nettype wire
